/* rtl/core/csv_field_splitter_core_defines.svh */
// Assertion helpers for the core top file.
`ifndef CSV_FIELD_SPLITTER_CORE_DEFINES_SVH
`define CSV_FIELD_SPLITTER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CSVFS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csvfs: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CSVFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csvfs: next-cycle check failed");

`endif

/* rtl/core/csvfs_pkg.sv */
`timescale 1ns / 1ps

package csvfs_pkg;

   localparam int OFFSET_BITS = 24;
   localparam int INDEX_BITS  = 16;
   localparam int LIMIT_BITS  = 16;
   localparam int CSR_ADDR_BITS = 8;

   typedef logic [OFFSET_BITS-1:0] off_type;
   typedef logic [INDEX_BITS-1:0]  idx_type;
   typedef logic [LIMIT_BITS-1:0]  limit_type;
   typedef logic [CSR_ADDR_BITS-1:0] csr_addr_type;

   localparam csr_addr_type CSR_COLUMN_LIMIT = csr_addr_type'(0);
   localparam csr_addr_type CSR_ROW_LIMIT    = csr_addr_type'(1);

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_COMMA = 8'h2c;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] MARK_0   = 8'hef;
   localparam logic [7:0] MARK_1   = 8'hbb;
   localparam logic [7:0] MARK_2   = 8'hbf;

   // Mark index code for a byte that is no byte-order-mark byte.
   localparam logic [1:0] MARK_NONE = 2'd3;

   typedef enum logic [2:0] {
      CLS_OTHER,
      CLS_QUOTE,
      CLS_COMMA,
      CLS_CR,
      CLS_LF
   } tok_class_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_file;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      idx_type    row_index;
      idx_type    column_index;
      off_type    start_offset;
      off_type    field_length;
      logic       ends_row;
      logic       out_of_range;
   } rsp_type;

   typedef struct packed {
      tok_class_type cls;
      logic [1:0]    mark_idx;
      logic          start_of_file;
      logic          last_byte;
   } tok_type;

   typedef struct packed {
      logic take;
      logic emit;
   } back_stat_type;

   function automatic off_type sat_off(input off_type v);
      return (v == '1) ? v : off_type'(v + 1'b1);
   endfunction

   function automatic idx_type sat_idx(input idx_type v);
      return (v == '1) ? v : idx_type'(v + 1'b1);
   endfunction

endpackage

/* rtl/core/csvfs_front.sv */
`timescale 1ns / 1ps

module csvfs_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  csvfs_pkg::req_type req_data,
   output logic               tok_valid,
   output csvfs_pkg::tok_type tok_data,
   input  logic               tok_take
);

   csvfs_pkg::tok_type q_ff [2];
   csvfs_pkg::tok_type tok_new;
   logic [1:0] count_ff, count_in;
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic       push_ok;

   // Classify the byte.
   always_comb begin
      tok_new.start_of_file = req_data.start_of_file;
      tok_new.last_byte     = req_data.last_byte;
      unique case (req_data.data_byte)
         csvfs_pkg::CH_QUOTE: tok_new.cls = csvfs_pkg::CLS_QUOTE;
         csvfs_pkg::CH_COMMA: tok_new.cls = csvfs_pkg::CLS_COMMA;
         csvfs_pkg::CH_CR:    tok_new.cls = csvfs_pkg::CLS_CR;
         csvfs_pkg::CH_LF:    tok_new.cls = csvfs_pkg::CLS_LF;
         default:             tok_new.cls = csvfs_pkg::CLS_OTHER;
      endcase
      unique case (req_data.data_byte)
         csvfs_pkg::MARK_0: tok_new.mark_idx = 2'd0;
         csvfs_pkg::MARK_1: tok_new.mark_idx = 2'd1;
         csvfs_pkg::MARK_2: tok_new.mark_idx = 2'd2;
         default:           tok_new.mark_idx = csvfs_pkg::MARK_NONE;
      endcase
   end

   assign req_full  = (count_ff == 2'd2);
   assign push_ok   = req_push && !req_full;
   assign tok_valid = (count_ff != 2'd0);
   assign tok_data  = q_ff[rd_ff];

   always_comb begin
      wr_in = push_ok  ? !wr_ff : wr_ff;
      rd_in = tok_take ? !rd_ff : rd_ff;
      unique case ({push_ok, tok_take})
         2'b10:   count_in = 2'(count_ff + 2'd1);
         2'b01:   count_in = 2'(count_ff - 2'd1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ff] <= tok_new;
      end
   end

endmodule

/* rtl/core/csvfs_back.sv */
`timescale 1ns / 1ps

module csvfs_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       tok_valid,
   input  csvfs_pkg::tok_type         tok_data,
   output logic                       tok_take,
   input  csvfs_pkg::limit_type       column_limit,
   input  csvfs_pkg::limit_type       row_limit,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output csvfs_pkg::rsp_type         rsp_data,
   output csvfs_pkg::back_stat_type   stat
);

   // Parse state
   csvfs_pkg::off_type pos_ff, pos_in;
   csvfs_pkg::off_type fs_ff, fs_in;
   csvfs_pkg::off_type qe_ff, qe_in;
   logic               qev_ff, qev_in;
   logic               inq_ff, inq_in;
   logic               cr_ff, cr_in;
   logic [1:0]         mm_ff, mm_in;
   csvfs_pkg::idx_type row_ff, row_in;
   csvfs_pkg::idx_type col_ff, col_in;

   // Working values after an optional start-of-file clear
   csvfs_pkg::off_type p, fs, qe, fs_mid, delim, len;
   logic               qev, inq, cr;
   logic [1:0]         mm;
   csvfs_pkg::idx_type row, col;
   logic               emit, ends;
   csvfs_pkg::rsp_type res;

   // Result queue
   csvfs_pkg::rsp_type oq_ff [2];
   logic [1:0] oq_cnt_ff, oq_cnt_in;
   logic       oq_wr_ff, oq_rd_ff;
   logic       pop_ok, push_ok, adv;

   always_comb begin
      p   = tok_data.start_of_file ? '0   : pos_ff;
      fs  = tok_data.start_of_file ? '0   : fs_ff;
      qe  = tok_data.start_of_file ? '0   : qe_ff;
      qev = tok_data.start_of_file ? 1'b0 : qev_ff;
      inq = tok_data.start_of_file ? 1'b0 : inq_ff;
      cr  = tok_data.start_of_file ? 1'b0 : cr_ff;
      mm  = tok_data.start_of_file ? 2'd0 : mm_ff;
      row = tok_data.start_of_file ? '0   : row_ff;
      col = tok_data.start_of_file ? '0   : col_ff;

      pos_in = csvfs_pkg::sat_off(p);
      fs_mid = fs;
      qe_in  = qe;
      qev_in = qev;
      inq_in = inq;
      cr_in  = 1'b0;
      mm_in  = mm;
      row_in = row;
      col_in = col;
      emit   = 1'b0;
      ends   = 1'b0;
      delim  = p;

      if (cr && tok_data.cls == csvfs_pkg::CLS_LF) begin
         // CR LF pair: the field ends at the CR
         emit  = 1'b1;
         ends  = 1'b1;
         delim = (p != '0) ? csvfs_pkg::off_type'(p - 1'b1) : '0;
      end else begin
         // track the byte-order mark over the first three bytes
         if (p < csvfs_pkg::off_type'(3) && csvfs_pkg::off_type'(mm) == p
             && tok_data.mark_idx == p[1:0]) begin
            mm_in = 2'(mm + 2'd1);
            if (mm == 2'd2) begin
               fs_mid = csvfs_pkg::off_type'(3);
            end
         end
         unique case (tok_data.cls)
            csvfs_pkg::CLS_QUOTE: begin
               if (inq) begin
                  inq_in = 1'b0;
                  if (!qev && p >= fs_mid) begin
                     qe_in  = p;
                     qev_in = 1'b1;
                  end
               end else begin
                  inq_in = 1'b1;
                  if (qev && qe < csvfs_pkg::sat_off(fs_mid)) begin
                     qev_in = 1'b0;
                  end
               end
            end
            csvfs_pkg::CLS_COMMA: emit = !inq;
            csvfs_pkg::CLS_CR:    cr_in = !tok_data.last_byte;
            csvfs_pkg::CLS_LF: begin
               emit = 1'b1;
               ends = 1'b1;
            end
            default: ;
         endcase
      end

      // opening quote moves the field start on by one byte
      fs_in = (tok_data.cls == csvfs_pkg::CLS_QUOTE && !inq && !(cr && 1'b0))
              ? csvfs_pkg::sat_off(fs_mid) : fs_mid;

      if (qev && qe >= fs_mid) begin
         len = csvfs_pkg::off_type'(qe - fs_mid);
      end else if (delim >= fs_mid) begin
         len = csvfs_pkg::off_type'(delim - fs_mid);
      end else begin
         len = '0;
      end

      res.row_index    = row;
      res.column_index = col;
      res.start_offset = fs_mid;
      res.field_length = len;
      res.ends_row     = ends;
      res.out_of_range = (32'(row) >= 32'(row_limit)) || (32'(col) >= 32'(column_limit));

      if (emit) begin
         qev_in = 1'b0;
         fs_in  = csvfs_pkg::sat_off(p);
         if (ends) begin
            row_in = csvfs_pkg::sat_idx(row);
            col_in = '0;
         end else begin
            col_in = csvfs_pkg::sat_idx(col);
         end
      end
   end

   assign pop_ok    = rsp_pop && (oq_cnt_ff != 2'd0);
   assign adv       = tok_valid && ((oq_cnt_ff != 2'd2) || pop_ok);
   assign push_ok   = adv && emit;
   assign tok_take  = adv;
   assign rsp_empty = (oq_cnt_ff == 2'd0);
   assign rsp_data  = oq_ff[oq_rd_ff];
   assign stat.take = adv;
   assign stat.emit = push_ok;

   always_comb begin
      unique case ({push_ok, pop_ok})
         2'b10:   oq_cnt_in = 2'(oq_cnt_ff + 2'd1);
         2'b01:   oq_cnt_in = 2'(oq_cnt_ff - 2'd1);
         default: oq_cnt_in = oq_cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         fs_ff     <= '0;
         qe_ff     <= '0;
         qev_ff    <= 1'b0;
         inq_ff    <= 1'b0;
         cr_ff     <= 1'b0;
         mm_ff     <= 2'd0;
         row_ff    <= '0;
         col_ff    <= '0;
         oq_cnt_ff <= 2'd0;
         oq_wr_ff  <= 1'b0;
         oq_rd_ff  <= 1'b0;
      end else begin
         if (adv) begin
            pos_ff <= pos_in;
            fs_ff  <= fs_in;
            qe_ff  <= qe_in;
            qev_ff <= qev_in;
            inq_ff <= inq_in;
            cr_ff  <= cr_in;
            mm_ff  <= mm_in;
            row_ff <= row_in;
            col_ff <= col_in;
         end
         oq_cnt_ff <= oq_cnt_in;
         oq_wr_ff  <= push_ok ? !oq_wr_ff : oq_wr_ff;
         oq_rd_ff  <= pop_ok  ? !oq_rd_ff : oq_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         oq_ff[oq_wr_ff] <= res;
      end
   end

endmodule

/* rtl/core/csv_field_splitter_core.sv */
`timescale 1ns / 1ps
// Path: a byte accepted into the front-end queue is classified there, parsed by the
// back end once the result queue has room, and any field record it ends is registered
// in the result queue. Throughput: one byte per cycle while the result queue has room or is popped.
// Reset: synchronous, active high; clears both queues and all parse state and sets
// both limits to 65535.
`include "csv_field_splitter_core_defines.svh"

module csv_field_splitter_core (
   input  logic                     clock,
   input  logic                     reset,
   // byte input
   input  logic                     req_push,
   output logic                     req_full,
   input  csvfs_pkg::req_type       req_data,
   // field records
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output csvfs_pkg::rsp_type       rsp_data,
   // limit registers
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  csvfs_pkg::csr_addr_type  csr_index,
   input  csvfs_pkg::limit_type     csr_wdata
);

   csvfs_pkg::limit_type      column_limit_ff;
   csvfs_pkg::limit_type      row_limit_ff;
   logic                      tok_valid;
   logic                      tok_take;
   csvfs_pkg::tok_type        tok_data;
   csvfs_pkg::back_stat_type  stat;

   // Writes must land only while idle; users keep to it, the block takes them at once, unchecked.
   assign csr_ready = 1'b1;

   // Hold the limits; drop writes to unknown indexes.
   always_ff @(posedge clock) begin
      if (reset) begin
         column_limit_ff <= '1;
         row_limit_ff    <= '1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            csvfs_pkg::CSR_COLUMN_LIMIT: column_limit_ff <= csr_wdata;
            csvfs_pkg::CSR_ROW_LIMIT:    row_limit_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Front end: classify each byte and queue it for the parser.
   csvfs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .tok_valid (tok_valid),
      .tok_data  (tok_data),
      .tok_take  (tok_take)
   );

   // Back end: parse one byte a cycle while the result queue has room; queue field records.
   csvfs_back u_back (
      .clock        (clock),
      .reset        (reset),
      .tok_valid    (tok_valid),
      .tok_data     (tok_data),
      .tok_take     (tok_take),
      .column_limit (column_limit_ff),
      .row_limit    (row_limit_ff),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_data     (rsp_data),
      .stat         (stat)
   );

   // Takes need a queued byte, records a take; full holds with no take, empty with no record.
   `CSVFS_ASSERT_IMPL(a_take_needs_tok, clock, reset, stat.take, tok_valid)
   `CSVFS_ASSERT_IMPL(a_emit_needs_take, clock, reset, stat.emit, stat.take)
   `CSVFS_ASSERT_NEXT(a_full_holds, clock, reset, req_full && !stat.take, req_full)
   `CSVFS_ASSERT_NEXT(a_empty_holds, clock, reset, rsp_empty && !stat.emit, rsp_empty)

endmodule
